>>> hdl/hme_pkg.sv
// shared constants, types and hash function for the hash map engine
package hme_pkg;

  localparam int unsigned BucketsDefault  = 64;
  localparam int unsigned WaysDefault     = 4;
  localparam int unsigned KeyBytesDefault = 4;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned OpWidth    = 3;
  localparam int unsigned TotalWidth = 9;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  typedef enum logic [OpWidth-1:0] {
    OpInsert   = 3'd0,
    OpGet      = 3'd1,
    OpRemove   = 3'd2,
    OpContains = 3'd3,
    OpClear    = 3'd4
  } op_e;

  // one byte of the reflected crc-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/hme_ram.sv
// generic simple dual-port synchronous ram with registered read
module hme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic [Width-1:0]                              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/hash_map_engine.sv
// top level of the crc-32 hashed key-value map, each bucket one row of the ram
// steps: hash (then the modulo states StMod and StFold when BUCKETS is not a power of two),
// bucket read, compare and write-back; the result strobe is registered from write-back
// busy holds off starts until write-back, so a new request waits for the last one to finish;
// a clear adds a sweep that zeroes every row
// reset runs the same sweep with busy high; the receiver cannot stall, one-cycle results
module hash_map_engine #(
  parameter int unsigned BUCKETS   = hme_pkg::BucketsDefault,
  parameter int unsigned WAYS      = hme_pkg::WaysDefault,
  parameter int unsigned KEY_BYTES = hme_pkg::KeyBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [hme_pkg::OpWidth-1:0]    opcode_i,
  input  logic [hme_pkg::KeyWidth-1:0]   lookup_key_i,
  input  logic [hme_pkg::DataWidth-1:0]  write_data_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic [hme_pkg::DataWidth-1:0]  read_data_o,
  output logic                           bucket_full_o,
  output logic [hme_pkg::TotalWidth-1:0] entry_total_o
);
  import hme_pkg::*;

  localparam int unsigned BktW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned Slots = BUCKETS * WAYS;
  localparam int unsigned CntW  = $clog2(Slots + 1);
  localparam int unsigned SlotW = 1 + KeyWidth + DataWidth;
  localparam int unsigned RowW  = WAYS * SlotW;
  localparam bit          Pow2  = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(BUCKETS));
  localparam int unsigned Lat   = Pow2 ? 3 : 5;

  // one-hot sequencer
  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StHash  = 7'b0000010,
    StMod   = 7'b0000100,
    StFold  = 7'b0001000,
    StRead  = 7'b0010000,
    StExec  = 7'b0100000,
    StSweep = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [OpWidth-1:0]   op_q;
  logic [KeyWidth-1:0]  key_q;
  logic [DataWidth-1:0] data_q;
  logic [BktW-1:0]      bkt_q;
  logic [BktW-1:0]      sweep_q;
  logic [31:0]          crc;
  logic [31:0]          crc_q;
  logic [31:0]          quot_q;
  logic [63:0]          prod;
  logic [31:0]          rem;
  logic                 sweep_last;

  // hash of the key bytes, bytes beyond the 32-bit key hashed as zero
  always_comb begin
    logic [31:0] c;
    logic [7:0]  b;
    c = 32'hFFFFFFFF;
    for (int i = 0; i < KEY_BYTES; i++) begin
      b = (i < 4) ? key_q[8*(i%4) +: 8] : 8'd0;
      c = crc_byte(c, b);
    end
    crc = ~c;
  end

  // modulo by a bucket count that is not a power of two: reciprocal estimate, then
  // one subtract since the estimate is at most one below the true quotient
  assign prod = {32'd0, crc_q} * {32'd0, Recip};
  always_comb begin
    rem = crc_q - quot_q * 32'(BUCKETS);
    if (rem >= 32'(BUCKETS)) begin
      rem = rem - 32'(BUCKETS);
    end
  end

  // row ram: every way's valid bit, key and data of a bucket side by side
  logic            row_we;
  logic [BktW-1:0] row_waddr;
  logic [RowW-1:0] row_wdata, row_rdata, row_new;

  hme_ram #(.Width(RowW), .Depth(BUCKETS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (bkt_q),
    .rdata_o (row_rdata)
  );

  logic [CntW-1:0] count_q;
  logic [WAYS-1:0] vrow;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      vrow[w] = row_rdata[w*SlotW];
    end
  end

  // way search: first hit and first free way
  logic            hit, has_free;
  logic [WAYS-1:0] hit_oh, free_oh;
  always_comb begin
    hit = 1'b0;
    has_free = 1'b0;
    hit_oh = '0;
    free_oh = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (vrow[w]) begin
        if (!hit && row_rdata[w*SlotW+1 +: KeyWidth] == key_q) begin
          hit = 1'b1;
          hit_oh[w] = 1'b1;
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
  end

  logic [DataWidth-1:0] hit_data;
  always_comb begin
    hit_data = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        hit_data = row_rdata[w*SlotW+1+KeyWidth +: DataWidth];
      end
    end
  end

  logic is_ins;
  assign is_ins = (state_q == StExec) && (op_q == OpInsert);

  // write-back row: patch the hit or free way on insert, drop the hit way on remove
  always_comb begin
    row_new = row_rdata;
    for (int w = 0; w < WAYS; w++) begin
      if (op_q == OpInsert) begin
        if (hit_oh[w]) begin
          row_new[w*SlotW+1+KeyWidth +: DataWidth] = data_q;
        end else if (!hit && free_oh[w]) begin
          row_new[w*SlotW] = 1'b1;
          row_new[w*SlotW+1 +: KeyWidth] = key_q;
          row_new[w*SlotW+1+KeyWidth +: DataWidth] = data_q;
        end
      end else if (op_q == OpRemove && hit_oh[w]) begin
        row_new[w*SlotW] = 1'b0;
      end
    end
  end

  // the sweep zeroes one row per cycle
  assign sweep_last = (sweep_q == BktW'(BUCKETS - 1));
  assign row_waddr  = (state_q == StSweep) ? sweep_q : bkt_q;
  assign row_wdata  = (state_q == StSweep) ? '0 : row_new;
  assign row_we     = (state_q == StSweep) ||
                      (state_q == StExec && ((op_q == OpInsert && (hit || has_free)) ||
                                             (op_q == OpRemove && hit)));

  logic [CntW-1:0] count_d;
  always_comb begin
    count_d = count_q;
    if (state_q == StExec) begin
      case (op_q)
        OpInsert: if (!hit && has_free) count_d = count_q + 1'b1;
        OpRemove: if (hit && count_q != '0) count_d = count_q - 1'b1;
        OpClear:  count_d = '0;
        default:  count_d = count_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (start) state_d = StHash;
      StHash: begin
        if (Pow2) state_d = StRead;
        else state_d = StMod;
      end
      StMod:   state_d = StFold;
      StFold:  state_d = StRead;
      StRead:  state_d = StExec;
      StExec: begin
        if (op_q == OpClear) state_d = StSweep;
        else state_d = StIdle;
      end
      StSweep: if (sweep_last) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign busy = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StSweep;
      count_q <= '0;
      done_o  <= 1'b0;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_o  <= (state_q == StExec);
      if (state_q == StSweep) begin
        sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
      end
    end
  end

  // request and result payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      op_q   <= opcode_i;
      key_q  <= lookup_key_i;
      data_q <= write_data_i;
    end
    if (state_q == StHash) begin
      crc_q <= crc;
      if (Pow2) begin
        bkt_q <= BktW'(crc & 32'(BUCKETS - 1));
      end
    end
    if (state_q == StMod) begin
      quot_q <= prod[63:32];
    end
    if (state_q == StFold) begin
      bkt_q <= BktW'(rem);
    end
    if (state_q == StExec) begin
      found_o <= hit && (op_q == OpInsert || op_q == OpGet || op_q == OpRemove ||
                         op_q == OpContains);
      read_data_o   <= (op_q == OpGet && hit) ? hit_data : '0;
      bucket_full_o <= is_ins && !hit && !has_free;
      entry_total_o <= (count_d > CntW'(511)) ? TotalWidth'(511) : TotalWidth'(count_d);
    end
  end

  // count never exceeds the slot total
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Slots))
    else $error("entry count overflow");
  // a result follows every accepted start at a fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> ##Lat done_o)
    else $error("missing result");
  // full only on insert without hit
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !(bucket_full_o && found_o))
    else $error("full and found together");
endmodule

>>> test/tb_top.sv
// self-checking testbench for the hash map engine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hme_pkg::*;

  localparam int unsigned NB = BucketsDefault;
  localparam int unsigned NW = WaysDefault;
  localparam int unsigned NK = KeyBytesDefault;
  localparam int unsigned RandItems = 1950;
  localparam longint CycleLimit = 1000000;

  // expected response of one request
  typedef struct {
    logic        found;
    logic [31:0] read_data;
    logic        bucket_full;
    logic [8:0]  entry_total;
  } resp_t;

  // predictor of the table plus queue of pending responses
  class map_scoreboard;
    bit          vld[NB*NW];
    logic [31:0] keys[NB*NW];
    logic [31:0] vals[NB*NW];
    int unsigned live;
    resp_t       pending[$];
    int          errors;
    int          checked;

    function int unsigned bucket_of(logic [31:0] k);
      logic [31:0] c;
      c = 32'hFFFFFFFF;
      for (int i = 0; i < NK; i++) begin
        logic [7:0] b;
        b = (i < 4) ? k[8*i +: 8] : 8'd0;
        c = c ^ {24'd0, b};
        for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      c = ~c;
      return c % NB;
    endfunction

    // apply one accepted request to the table copy
    function void note_request(logic [2:0] op, logic [31:0] k, logic [31:0] d);
      int unsigned base;
      int hit, free_s;
      resp_t r;
      base = bucket_of(k) * NW;
      hit = -1;
      free_s = -1;
      r = '{1'b0, 32'd0, 1'b0, 9'd0};
      for (int w = 0; w < NW; w++) begin
        if (vld[base+w]) begin
          if (hit < 0 && keys[base+w] == k) hit = base + w;
        end else if (free_s < 0) free_s = base + w;
      end
      case (op)
        OpInsert: begin
          if (hit >= 0) begin
            r.found = 1;
            vals[hit] = d;
          end else if (free_s >= 0) begin
            vld[free_s] = 1;
            keys[free_s] = k;
            vals[free_s] = d;
            live++;
          end else r.bucket_full = 1;
        end
        OpGet: if (hit >= 0) begin
          r.found = 1;
          r.read_data = vals[hit];
        end
        OpRemove: if (hit >= 0) begin
          r.found = 1;
          vld[hit] = 0;
          if (live > 0) live--;
        end
        OpContains: if (hit >= 0) r.found = 1;
        OpClear: begin
          foreach (vld[i]) vld[i] = 0;
          live = 0;
        end
        default: ;
      endcase
      r.entry_total = (live > 511) ? 9'd511 : live[8:0];
      pending.push_back(r);
    endfunction

    // compare one strobed response with the oldest expectation
    function void check_response(logic f, logic [31:0] rd, logic bf, logic [8:0] tot);
      resp_t e;
      if (pending.size() == 0) begin
        $error("response with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (f !== e.found) begin
        $error("found exp %0d got %0d", e.found, f);
        errors++;
      end
      if (rd !== e.read_data) begin
        $error("read_data exp %h got %h", e.read_data, rd);
        errors++;
      end
      if (bf !== e.bucket_full) begin
        $error("bucket_full exp %0d got %0d", e.bucket_full, bf);
        errors++;
      end
      if (tot !== e.entry_total) begin
        $error("entry_total exp %0d got %0d", e.entry_total, tot);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni, start, busy;
  logic [2:0]  opcode_i;
  logic [31:0] lookup_key_i, write_data_i;
  logic        done_o, found_o, bucket_full_o;
  logic [31:0] read_data_o;
  logic [8:0]  entry_total_o;

  map_scoreboard sb;
  longint cycles;
  int      n_sent;
  logic [31:0] key_pool[32];
  logic [31:0] same_bucket[8];

  hash_map_engine u_top (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // response side: the engine cannot be stalled, so sample every strobe
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) sb.check_response(found_o, read_data_o, bucket_full_o, entry_total_o);
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // random idle gap, mostly short with an occasional long one
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk_i);
  endtask

  // one start transfer; start stays high until the engine takes it
  task automatic send_request(logic [2:0] op, logic [31:0] k, logic [31:0] d);
    start <= 1'b1;
    opcode_i <= op;
    lookup_key_i <= k;
    write_data_i <= d;
    do @(posedge clk_i); while (busy);
    sb.note_request(op, k, d);
    n_sent++;
    start <= 1'b0;
    opcode_i <= 3'($urandom);
    lookup_key_i <= $urandom;
    write_data_i <= $urandom;
    // the engine is busy right after a transfer, so this costs no throughput
    @(posedge clk_i);
  endtask

  initial begin
    logic [2:0] op;
    logic [31:0] k;
    int p, nb;
    sb = new();
    cycles = 0;
    n_sent = 0;
    rst_ni = 0;
    start = 0;
    opcode_i = '0;
    lookup_key_i = '0;
    write_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keys sharing one bucket, to fill it and hit the full case
    nb = 0;
    k = 32'h1000;
    while (nb < 8) begin
      if (sb.bucket_of(k) == sb.bucket_of(32'h0)) begin
        same_bucket[nb] = k;
        nb++;
      end
      k++;
    end

    // directed: extremes, each opcode, full bucket, misses, unused opcodes
    send_request(OpGet, 32'h0, 32'hFFFFFFFF);
    send_request(OpRemove, 32'hFFFFFFFF, 32'h0);
    send_request(OpInsert, 32'h0, 32'hFFFFFFFF);
    send_request(OpInsert, 32'hFFFFFFFF, 32'h0);
    send_request(OpGet, 32'h0, 32'h0);
    send_request(OpInsert, 32'h0, 32'hA5A5A5A5);
    send_request(OpGet, 32'h0, 32'h0);
    for (int i = 0; i < 5; i++) send_request(OpInsert, same_bucket[i], ~same_bucket[i]);
    send_request(OpContains, same_bucket[2], 32'h0);
    send_request(OpContains, same_bucket[7], 32'h0);
    send_request(OpRemove, same_bucket[1], 32'h0);
    send_request(OpInsert, same_bucket[6], 32'h1234);
    send_request(OpGet, same_bucket[6], 32'h0);
    send_request(3'd5, 32'h0, 32'hFFFFFFFF);
    send_request(3'd6, 32'hFFFFFFFF, 32'h0);
    send_request(3'd7, 32'h0, 32'h0);
    send_request(OpClear, 32'h0, 32'h0);
    send_request(OpGet, 32'h0, 32'h0);

    // random: mostly keys from a small pool so hits and full buckets occur
    foreach (key_pool[i]) key_pool[i] = (i < 8) ? same_bucket[i] : $urandom;
    for (int i = 0; i < RandItems; i++) begin
      p = $urandom_range(0, 99);
      if (p < 40) op = OpInsert;
      else if (p < 60) op = OpGet;
      else if (p < 78) op = OpRemove;
      else if (p < 93) op = OpContains;
      else if (p < 95) op = OpClear;
      else op = 3'($urandom_range(0, 7));
      k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 31)] : $urandom;
      send_request(op, k, $urandom);
      idle_gap();
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d requests over all opcodes, checked %0d responses", n_sent, sb.checked);
    $display("covered hits, misses, updates, full buckets, clears and unused opcodes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
